@@ rtl/smpwm_pkg.sv @@
// Shared types, codes and channel-update functions of the shadowed multichannel PWM.
package smpwm_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_RESET = 2'd3
    } req_t;

    // Register offsets within one channel's eight-word window
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_PERIOD = 3'd2;
    localparam logic [2:0] REG_FP     = 3'd3;

    // ctrl bit positions
    localparam int CTL_START_BIT  = 0;
    localparam int CTL_UPDATE_BIT = 2;
    localparam int CTL_CONT_BIT   = 5;
    localparam int CTL_FPOUT_BIT  = 8;

    // Strobe bits that are never stored in ctrl
    localparam logic [31:0] CTL_STROBE_MASK = 32'h0000_0005;

    // Widths of the stream payloads
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;
    localparam int LEVEL_W    = 6;
    localparam int MAX_CH     = 8;

    // Complete state of one channel
    typedef struct packed {
        logic [31:0] shadow_ctrl;
        logic [31:0] shadow_period;
        logic [31:0] shadow_fall;
        logic [31:0] live_ctrl;
        logic [31:0] live_period;
        logic [31:0] live_fall;
        logic        run;
        logic        upd;
        logic        bnd;
        logic        lvl;
        logic [31:0] cnt;
    } ch_t;

    // Level at the start of a period for the live set
    function automatic logic start_level(ch_t c);
        logic res;
        if (!c.live_ctrl[CTL_CONT_BIT] || c.live_period == 32'd0)
            res = 1'b0;
        else if (c.live_ctrl[CTL_FPOUT_BIT])
            res = (c.live_fall != 32'd0);
        else
            res = (c.live_fall == 32'd0);
        return res;
    endfunction

    // Copy the shadow set into the live set
    function automatic ch_t copy_set(ch_t c);
        ch_t r;
        r             = c;
        r.live_ctrl   = c.shadow_ctrl;
        r.live_period = c.shadow_period;
        r.live_fall   = c.shadow_fall;
        r.upd         = 1'b0;
        return r;
    endfunction

    // Begin a new period: take a pending update, then either stop or schedule
    function automatic ch_t period_start(ch_t c);
        ch_t r;
        r = c;
        if (r.upd)
            r = copy_set(r);
        if (!r.live_ctrl[CTL_CONT_BIT] || r.live_period == 32'd0) begin
            r.run = 1'b0;
            r.cnt = 32'd0;
            r.lvl = 1'b0;
        end
        else begin
            r.lvl = start_level(r);
            if (r.live_fall != 32'd0 && r.live_fall < r.live_period) begin
                r.cnt = r.live_fall;
                r.bnd = 1'b0;
            end
            else begin
                r.cnt = r.live_period;
                r.bnd = 1'b1;
            end
        end
        return r;
    endfunction

    // Scheduled edge: either a period boundary or the falling point
    function automatic ch_t edge_fire(ch_t c);
        ch_t         r;
        logic [31:0] rest;
        r    = c;
        rest = c.live_period - c.live_fall;
        if (c.bnd)
            r = period_start(c);
        else begin
            r.lvl = !start_level(c);
            r.cnt = (rest == 32'd0) ? 32'd1 : rest;
            r.bnd = 1'b1;
        end
        return r;
    endfunction

    // Bus write to ctrl: store without strobes, flag update, start if idle
    function automatic ch_t ctrl_write(ch_t c, logic [31:0] v);
        ch_t r;
        r             = c;
        r.shadow_ctrl = v & ~CTL_STROBE_MASK;
        if (v[CTL_UPDATE_BIT])
            r.upd = 1'b1;
        if (v[CTL_START_BIT] && !c.run) begin
            r     = copy_set(r);
            r.run = 1'b1;
            r     = period_start(r);
        end
        return r;
    endfunction

endpackage

@@ rtl/shadowed_multichannel_pwm.sv @@
// Top level of the shadowed multichannel PWM: input register, channel update, result register.
//
// Usage: each transfer on the slave stream is one request. tuser carries the
// kind (bus read, bus write, one PWM clock tick, reset pulse) and tdata the
// word address and write data. Each request yields exactly one transfer on
// the master stream with the read data, the level of every channel and the
// mask of running channels after the request.
// Throughput: one request per cycle while the receiver keeps tready high.
// Each request passes through the input register and then the result
// register; all channels update in parallel while the request sits in
// the input register.
// Stalls: when the receiver holds tready low the result register holds,
// the input register fills, and then the slave tready drops; nothing is lost.
// Reset: rst_n clears all channel registers, shadow and live sets and the
// valid flags of both pipeline registers. A reset-pulse request clears the
// channel state in-band and reports the cleared state.
// Channels beyond CHANNELS read 0 and ignore writes; the level and running
// fields show the first six channels.
module shadowed_multichannel_pwm
    import smpwm_pkg::*;
#(
    parameter int CHANNELS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [5:0] word_addr, [37:6] write_data, [39:38] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] read_data, [37:32] pwm_levels, [43:38] running_mask, [47:44] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Input register
    logic        in_valid_reg;
    req_t        in_req_reg;
    logic [5:0]  in_addr_reg;
    logic [31:0] in_data_reg;

    // Result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    // Channel state
    ch_t ch_reg  [CHANNELS];
    ch_t ch_next [CHANNELS];

    logic              out_free;
    logic              in_take;
    logic              proc;
    logic [2:0]        ch_sel;
    logic [2:0]        reg_sel;
    logic [31:0]       rd_data;
    logic [MAX_CH-1:0] lvl_all;
    logic [MAX_CH-1:0] run_all;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign ch_sel        = in_addr_reg[5:3];
    assign reg_sel       = in_addr_reg[2:0];

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (out_free)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_req_reg  <= req_t'(s_axis_tuser);
            in_addr_reg <= s_axis_tdata[5:0];
            in_data_reg <= s_axis_tdata[37:6];
        end
    end

    // Advance every channel for the request in the input register
    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            ch_next[k] = ch_reg[k];
            unique case (in_req_reg)
                REQ_READ: ;
                REQ_WRITE:
                begin
                    if (ch_sel == 3'(k))
                    begin
                        case (reg_sel)
                            REG_CTRL:   ch_next[k] = ctrl_write(ch_reg[k], in_data_reg);
                            REG_PERIOD: ch_next[k].shadow_period = in_data_reg;
                            REG_FP:     ch_next[k].shadow_fall = in_data_reg;
                            default: ;
                        endcase
                    end
                end
                REQ_TICK:
                begin
                    if (ch_reg[k].run)
                    begin
                        if (ch_reg[k].cnt <= 32'd1)
                        begin
                            ch_next[k].cnt = 32'd0;
                            ch_next[k]     = edge_fire(ch_next[k]);
                        end
                        else
                            ch_next[k].cnt = ch_reg[k].cnt - 32'd1;
                    end
                end
                REQ_RESET: ch_next[k] = '0;
            endcase
        end
    end

    // Read the addressed shadow register
    always_comb
    begin
        rd_data = 32'd0;
        if (in_req_reg == REQ_READ)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                if (ch_sel == 3'(k))
                begin
                    case (reg_sel)
                        REG_CTRL:   rd_data = ch_reg[k].shadow_ctrl;
                        REG_PERIOD: rd_data = ch_reg[k].shadow_period;
                        REG_FP:     rd_data = ch_reg[k].shadow_fall;
                        default:    rd_data = 32'd0;
                    endcase
                end
            end
        end
    end

    // Gather levels and running flags after the request
    always_comb
    begin
        lvl_all = '0;
        run_all = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            lvl_all[k] = ch_next[k].lvl;
            run_all[k] = ch_next[k].run;
        end
    end

    assign out_data_next = {4'b0, run_all[LEVEL_W-1:0], lvl_all[LEVEL_W-1:0], rd_data};

    // Commit channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
                ch_reg[k] <= '0;
        end
        else if (proc)
        begin
            for (int k = 0; k < CHANNELS; k++)
                ch_reg[k] <= ch_next[k];
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // A request other than a read returns zero read data
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_req_reg != REQ_READ |=> m_axis_tdata[31:0] == 32'd0)
        else $error("read data not zero for a non-read request");

    // A reset pulse reports every channel stopped and low
    a_reset_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_req_reg == REQ_RESET |=> m_axis_tdata[43:32] == 12'd0)
        else $error("reset pulse left a channel active");

    // A held request is not dropped while the result register is blocked
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_addr_reg))
        else $error("stalled request lost");

    // Channel 0, when stopped, keeps no count and drives low
    a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        !ch_reg[0].run |-> ch_reg[0].cnt == 32'd0 && !ch_reg[0].lvl)
        else $error("stopped channel holds a count or a high level");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the shadowed multichannel PWM stream block.
`timescale 1ns / 100ps

module testbench;

    import smpwm_pkg::*;

    localparam int NUM_CH     = 6;
    localparam int ITEM_GOAL  = 1900;
    localparam int DRAIN_WAIT = 20;
    localparam int CYCLE_CAP  = 400000;

    // Reserved words inside a channel window
    localparam logic [2:0] REG_RSVD1 = 3'd1;
    localparam logic [2:0] REG_RSVD7 = 3'd7;

    // ctrl values used by the directed rows
    localparam logic [31:0] CTL_START  = 32'h1 << CTL_START_BIT;
    localparam logic [31:0] CTL_UPDATE = 32'h1 << CTL_UPDATE_BIT;
    localparam logic [31:0] CTL_CONT   = 32'h1 << CTL_CONT_BIT;
    localparam logic [31:0] CTL_FPOUT  = 32'h1 << CTL_FPOUT_BIT;

    typedef struct packed {
        logic [31:0] rd;
        logic [5:0]  lv;
        logic [5:0]  rn;
    } pwm_result_t;

    typedef struct {
        req_t        req;
        logic [5:0]  addr;
        logic [31:0] data;
        bit          typed;
        pwm_result_t res;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = 2'd0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Predicted channel state
    logic [31:0] sh_ctrl [NUM_CH];
    logic [31:0] sh_period [NUM_CH];
    logic [31:0] sh_fp [NUM_CH];
    logic [31:0] act_ctrl [NUM_CH];
    logic [31:0] act_period [NUM_CH];
    logic [31:0] act_fp [NUM_CH];
    logic        running [NUM_CH];
    logic        pend_upd [NUM_CH];
    logic        at_bound [NUM_CH];
    logic        level [NUM_CH];
    logic [31:0] ticks_left [NUM_CH];

    pwm_result_t pwm_result_q[$];
    stim_row_t   directed_rows[$];

    int err_cnt;
    int sent_cnt;
    int seen_cnt;
    int tick_cnt;
    int rstp_cnt;
    int cyc_cnt;
    bit src_burst;
    bit snk_burst;

    shadowed_multichannel_pwm #(.CHANNELS(NUM_CH)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_CAP)
        begin
            $display("%0t timeout after %0d cycles", $time, cyc_cnt);
            $display("shadowed_multichannel_pwm verification failed");
            $finish;
        end
    end

    function automatic logic [5:0] waddr(int ch, logic [2:0] r);
        logic [2:0] c;
        c = ch[2:0];
        return {c, r};
    endfunction

    // Clear every channel to its reset state
    function automatic void clear_channels();
        for (int i = 0; i < NUM_CH; i++)
        begin
            sh_ctrl[i]    = '0;
            sh_period[i]  = '0;
            sh_fp[i]      = '0;
            act_ctrl[i]   = '0;
            act_period[i] = '0;
            act_fp[i]     = '0;
            running[i]    = 1'b0;
            pend_upd[i]   = 1'b0;
            at_bound[i]   = 1'b0;
            level[i]      = 1'b0;
            ticks_left[i] = '0;
        end
    endfunction

    // Level at the start of a period for the active set
    function automatic logic period_level(int c);
        if (!act_ctrl[c][CTL_CONT_BIT] || act_period[c] == 32'd0)
            return 1'b0;
        if (act_ctrl[c][CTL_FPOUT_BIT])
            return act_fp[c] != 32'd0;
        return act_fp[c] == 32'd0;
    endfunction

    function automatic void load_shadow(int c);
        act_ctrl[c]   = sh_ctrl[c];
        act_period[c] = sh_period[c];
        act_fp[c]     = sh_fp[c];
        pend_upd[c]   = 1'b0;
    endfunction

    // A zero count is taken as a count of one
    function automatic void schedule(int c, logic [31:0] n, logic bnd);
        ticks_left[c] = (n == 32'd0) ? 32'd1 : n;
        at_bound[c]   = bnd;
    endfunction

    // Open a period: take a pending update, then stop or schedule the next edge
    function automatic void open_period(int c);
        if (pend_upd[c])
            load_shadow(c);
        if (!act_ctrl[c][CTL_CONT_BIT] || act_period[c] == 32'd0)
        begin
            running[c]    = 1'b0;
            ticks_left[c] = '0;
            level[c]      = 1'b0;
        end
        else
        begin
            level[c] = period_level(c);
            if (act_fp[c] != 32'd0 && act_fp[c] < act_period[c])
                schedule(c, act_fp[c], 1'b0);
            else
                schedule(c, act_period[c], 1'b1);
        end
    endfunction

    // Apply one request and return the result it produces
    function automatic pwm_result_t predict_pwm(req_t req, logic [5:0] addr, logic [31:0] data);
        pwm_result_t r;
        int          c;
        logic [2:0]  rg;
        c  = int'(addr[5:3]);
        rg = addr[2:0];
        r  = '0;
        case (req)
            REQ_READ:
                if (c < NUM_CH)
                begin
                    if (rg == REG_CTRL)
                        r.rd = sh_ctrl[c];
                    else if (rg == REG_PERIOD)
                        r.rd = sh_period[c];
                    else if (rg == REG_FP)
                        r.rd = sh_fp[c];
                end
            REQ_WRITE:
                if (c < NUM_CH)
                begin
                    if (rg == REG_CTRL)
                    begin
                        sh_ctrl[c] = data & ~(CTL_START | CTL_UPDATE);
                        if (data[CTL_UPDATE_BIT])
                            pend_upd[c] = 1'b1;
                        if (data[CTL_START_BIT] && !running[c])
                        begin
                            load_shadow(c);
                            running[c] = 1'b1;
                            open_period(c);
                        end
                    end
                    else if (rg == REG_PERIOD)
                        sh_period[c] = data;
                    else if (rg == REG_FP)
                        sh_fp[c] = data;
                end
            REQ_TICK:
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (running[i])
                    begin
                        if (ticks_left[i] <= 32'd1)
                        begin
                            ticks_left[i] = '0;
                            if (at_bound[i])
                                open_period(i);
                            else
                            begin
                                level[i] = !period_level(i);
                                schedule(i, act_period[i] - act_fp[i], 1'b1);
                            end
                        end
                        else
                            ticks_left[i] = ticks_left[i] - 32'd1;
                    end
                end
            default:
                clear_channels();
        endcase
        for (int i = 0; i < NUM_CH; i++)
        begin
            r.lv[i] = level[i];
            r.rn[i] = running[i];
        end
        return r;
    endfunction

    function automatic void add_row(req_t req, logic [5:0] addr, logic [31:0] data,
                                    bit typed, logic [31:0] rd, logic [5:0] lv,
                                    logic [5:0] rn);
        stim_row_t row;
        row.req    = req;
        row.addr   = addr;
        row.data   = data;
        row.typed  = typed;
        row.res.rd = rd;
        row.res.lv = lv;
        row.res.rn = rn;
        directed_rows.push_back(row);
    endfunction

    // Send one request; typed rows queue their fixed expectation
    task automatic send(req_t req, logic [5:0] addr, logic [31:0] data,
                        bit typed, pwm_result_t fixed);
        int          gap;
        pwm_result_t pred;
        gap = src_burst ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 49) == 0)
            src_burst = !src_burst;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, data, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = predict_pwm(req, addr, data);
        pwm_result_q.push_back(typed ? fixed : pred);
        sent_cnt++;
        if (req == REQ_TICK)
            tick_cnt++;
        if (req == REQ_RESET)
            rstp_cnt++;
    endtask

    task automatic send_plain(req_t req, logic [5:0] addr, logic [31:0] data);
        send(req, addr, data, 1'b0, '0);
    endtask

    task automatic tick_burst(int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_plain(REQ_READ, 6'($urandom_range(0, 43)), $urandom);
            else
                send_plain(REQ_TICK, 6'($urandom_range(0, 43)), $urandom);
        end
    endtask

    // Result side: random stalls, compare each transfer with the oldest prediction
    initial
    begin
        int          stall;
        pwm_result_t got;
        pwm_result_t want;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = snk_burst ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 49) == 0)
                snk_burst = !snk_burst;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got.rd = m_axis_tdata[31:0];
            got.lv = m_axis_tdata[37:32];
            got.rn = m_axis_tdata[43:38];
            seen_cnt++;
            if (pwm_result_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                err_cnt++;
            end
            else
            begin
                want = pwm_result_q.pop_front();
                if (got.rd !== want.rd)
                begin
                    $display("%0t read_data: expected %h actual %h", $time, want.rd, got.rd);
                    err_cnt++;
                end
                if (got.lv !== want.lv)
                begin
                    $display("%0t pwm_levels: expected %b actual %b", $time, want.lv, got.lv);
                    err_cnt++;
                end
                if (got.rn !== want.rn)
                begin
                    $display("%0t running_mask: expected %b actual %b", $time, want.rn,
                             got.rn);
                    err_cnt++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int          ch;
        int          sel;
        logic [31:0] per;
        logic [31:0] fpt;
        logic [31:0] ctl;
        bit          paused;
        err_cnt   = 0;
        sent_cnt  = 0;
        seen_cnt  = 0;
        tick_cnt  = 0;
        rstp_cnt  = 0;
        cyc_cnt   = 0;
        src_burst = 1'b0;
        snk_burst = 1'b0;
        paused    = 1'b0;
        clear_channels();

        // Directed table: fixed results where they are obvious
        add_row(REQ_READ,  waddr(0, REG_CTRL),   32'h0,        1, 32'h0,        6'h0, 6'h0);
        add_row(REQ_WRITE, waddr(0, REG_CTRL),   32'hFFFFFFFF, 1, 32'h0,        6'h0, 6'h0);
        add_row(REQ_READ,  waddr(0, REG_CTRL),   32'h0,        1, 32'hFFFFFFFA, 6'h0, 6'h0);
        add_row(REQ_WRITE, waddr(5, REG_PERIOD), 32'hFFFFFFFF, 1, 32'h0,        6'h0, 6'h0);
        add_row(REQ_READ,  waddr(5, REG_PERIOD), 32'h0,        1, 32'hFFFFFFFF, 6'h0, 6'h0);
        add_row(REQ_WRITE, waddr(5, REG_RSVD1),  32'hFFFFFFFF, 1, 32'h0,        6'h0, 6'h0);
        add_row(REQ_READ,  waddr(5, REG_RSVD1),  32'h0,        1, 32'h0,        6'h0, 6'h0);
        add_row(REQ_READ,  waddr(4, REG_RSVD7),  32'h0,        1, 32'h0,        6'h0, 6'h0);
        // Start channel 0 with a falling point inside the period
        add_row(REQ_WRITE, waddr(0, REG_PERIOD), 32'd4, 0, '0, '0, '0);
        add_row(REQ_WRITE, waddr(0, REG_FP),     32'd1, 0, '0, '0, '0);
        add_row(REQ_WRITE, waddr(0, REG_CTRL),   CTL_START | CTL_CONT, 0, '0, '0, '0);
        repeat (3) add_row(REQ_TICK, 6'd0, 32'd0, 0, '0, '0, '0);
        // Start while running, with an update to a zero falling point
        add_row(REQ_WRITE, waddr(0, REG_CTRL),
                CTL_START | CTL_UPDATE | CTL_CONT | CTL_FPOUT, 0, '0, '0, '0);
        add_row(REQ_WRITE, waddr(0, REG_FP), 32'd0, 0, '0, '0, '0);
        repeat (4) add_row(REQ_TICK, 6'd0, 32'd0, 0, '0, '0, '0);
        // Update to a non-continuous set: stop at the boundary
        add_row(REQ_WRITE, waddr(0, REG_CTRL), CTL_UPDATE, 0, '0, '0, '0);
        repeat (4) add_row(REQ_TICK, 6'd0, 32'd0, 0, '0, '0, '0);
        add_row(REQ_RESET, 6'd0, 32'd0, 1, 32'h0, 6'h0, 6'h0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send(directed_rows[k].req, directed_rows[k].addr, directed_rows[k].data,
                 directed_rows[k].typed, directed_rows[k].res);

        // Random part: mostly well-formed set-ups followed by ticks
        while (sent_cnt < ITEM_GOAL + directed_rows.size())
        begin
            sel = $urandom_range(0, 99);
            ch  = $urandom_range(0, NUM_CH - 1);
            if (sel < 40)
            begin
                per = (sel < 3) ? $urandom : $urandom_range(0, 12);
                fpt = $urandom_range(0, per[3:0] + 2);
                ctl = $urandom;
                ctl[CTL_CONT_BIT]  = ($urandom_range(0, 9) != 0);
                ctl[CTL_START_BIT] = 1'b1;
                send_plain(REQ_WRITE, waddr(ch, REG_PERIOD), per);
                send_plain(REQ_WRITE, waddr(ch, REG_FP), fpt);
                send_plain(REQ_WRITE, waddr(ch, REG_CTRL), ctl);
                tick_burst($urandom_range(1, 30));
            end
            else if (sel < 60)
            begin
                per = $urandom_range(0, 12);
                fpt = $urandom_range(0, per[3:0] + 2);
                ctl = $urandom;
                ctl[CTL_CONT_BIT]   = ($urandom_range(0, 5) != 0);
                ctl[CTL_UPDATE_BIT] = 1'b1;
                send_plain(REQ_WRITE, waddr(ch, REG_PERIOD), per);
                send_plain(REQ_WRITE, waddr(ch, REG_FP), fpt);
                send_plain(REQ_WRITE, waddr(ch, REG_CTRL), ctl);
                tick_burst($urandom_range(1, 20));
            end
            else if (sel < 80)
                tick_burst($urandom_range(1, 16));
            else if (sel < 99)
                send_plain(req_t'($urandom_range(0, 2)), 6'($urandom_range(0, 43)), $urandom);
            else
                send_plain(REQ_RESET, 6'($urandom_range(0, 43)), $urandom);

            // Hold off the sender once until the pipeline has drained
            if (!paused && sent_cnt > ITEM_GOAL / 2)
            begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (pwm_result_q.size() != 0)
                    @(posedge clk);
            end
        end

        // Drain and settle
        s_axis_tvalid <= 1'b0;
        while (pwm_result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d requests sent (%0d ticks, %0d reset pulses), %0d results compared",
                 sent_cnt, tick_cnt, rstp_cnt, seen_cnt);
        $display("%0d mismatches, random source and sink stalls throughout", err_cnt);
        if (err_cnt == 0 && pwm_result_q.size() == 0)
            $display("shadowed_multichannel_pwm verification clean");
        else
            $display("shadowed_multichannel_pwm verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/smpwm_pkg.sv
rtl/shadowed_multichannel_pwm.sv
test/testbench.sv
